@@ hdl/gbi_pkg.sv @@
package gbi_pkg;

    localparam int IDX_W      = 12;
    localparam int FRAC_MAX_W = 16;
    localparam int SAMPLE_W   = 16;
    localparam int OUT_W      = 24;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    typedef struct packed {
        logic                        is_query;
        logic [IDX_W-1:0]            col0;
        logic [IDX_W-1:0]            col1;
        logic [IDX_W-1:0]            row0;
        logic [IDX_W-1:0]            row1;
        logic [FRAC_MAX_W-1:0]       fx;
        logic [FRAC_MAX_W-1:0]       fy;
        logic signed [SAMPLE_W-1:0]  sample;
    } gbi_item_t;

    typedef enum logic {
        PH_ROW0,
        PH_ROW1
    } gbi_phase_t;

endpackage

@@ hdl/gbi_front.sv @@
module gbi_front
    import gbi_pkg::*;
#(
    parameter int MAX_COLS  = 256,
    parameter int MAX_ROWS  = 256,
    parameter int FRAC_BITS = 8
) (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,   // write_col, write_row, sample_height, x_pos, y_pos
    input  logic                          s_tuser,   // kind
    input  logic [$clog2(MAX_COLS)-1:0]   last_col,
    input  logic [$clog2(MAX_ROWS)-1:0]   last_row,
    input  logic                          q_full,
    output logic                          q_push,
    output gbi_item_t                     q_item
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);

    logic [7:0]          write_col;
    logic [7:0]          write_row;
    logic [15:0]         sample_height;
    logic [15:0]         x_pos;
    logic [15:0]         y_pos;
    logic                is_query;
    logic [16:0]         x_int;
    logic [16:0]         y_int;
    logic                at_col;
    logic                at_row;
    logic [CW-1:0]       col0;
    logic [CW-1:0]       col1;
    logic [RW-1:0]       row0;
    logic [RW-1:0]       row1;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic                in_range;

    assign write_col     = s_tdata[7:0];
    assign write_row     = s_tdata[15:8];
    assign sample_height = s_tdata[31:16];
    assign x_pos         = s_tdata[47:32];
    assign y_pos         = s_tdata[63:48];
    assign is_query      = (s_tuser == KIND_QUERY);

    // clamp integer parts, at the last column or row the fraction drops out
    assign x_int  = {1'b0, x_pos} >> FRAC_BITS;
    assign y_int  = {1'b0, y_pos} >> FRAC_BITS;
    assign at_col = x_int >= 17'(last_col);
    assign at_row = y_int >= 17'(last_row);
    assign col0   = at_col ? last_col : x_int[CW-1:0];
    assign row0   = at_row ? last_row : y_int[RW-1:0];
    assign col1   = at_col ? last_col : CW'(col0 + 1'b1);
    assign row1   = at_row ? last_row : RW'(row0 + 1'b1);
    assign fx     = at_col ? '0 : x_pos[FRAC_BITS-1:0];
    assign fy     = at_row ? '0 : y_pos[FRAC_BITS-1:0];

    assign in_range = (32'(write_col) < MAX_COLS) && (32'(write_row) < MAX_ROWS);

    always_comb begin
        q_item.is_query = is_query;
        q_item.sample   = $signed(sample_height);
        if (is_query) begin
            q_item.col0 = IDX_W'(col0);
            q_item.col1 = IDX_W'(col1);
            q_item.row0 = IDX_W'(row0);
            q_item.row1 = IDX_W'(row1);
            q_item.fx   = FRAC_MAX_W'(fx);
            q_item.fy   = FRAC_MAX_W'(fy);
        end else begin
            q_item.col0 = IDX_W'(write_col);
            q_item.col1 = IDX_W'(write_col);
            q_item.row0 = IDX_W'(write_row);
            q_item.row1 = IDX_W'(write_row);
            q_item.fx   = '0;
            q_item.fy   = '0;
        end
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && (is_query || in_range);

endmodule

@@ hdl/gbi_fifo.sv @@
module gbi_fifo
    import gbi_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  gbi_item_t item_in,
    output logic      full,
    input  logic      pop,
    output gbi_item_t item_out,
    output logic      empty
);

    gbi_item_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign item_out = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

@@ hdl/gbi_back.sv @@
module gbi_back
    import gbi_pkg::*;
#(
    parameter int MAX_COLS  = 256,
    parameter int MAX_ROWS  = 256,
    parameter int FRAC_BITS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  gbi_item_t         q_head,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata    // height_out
);

    localparam int CW  = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int AW  = CW + RW;
    localparam int HXW = SAMPLE_W + FRAC_BITS;
    localparam int PW  = HXW + FRAC_BITS + 2;
    localparam int SW  = (PW > OUT_W + 1) ? PW : OUT_W + 1;

    logic signed [SAMPLE_W-1:0] grid_mem [2**AW];

    gbi_phase_t phase_reg;
    gbi_phase_t phase_next;

    logic          adv;
    logic          issue;
    logic          we;
    logic          re;
    logic [RW-1:0] row_sel;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
    logic [AW-1:0] waddr;

    logic                       s1_vld_reg;
    gbi_phase_t                 s1_ph_reg;
    logic signed [SAMPLE_W-1:0] s1_a_reg;
    logic signed [SAMPLE_W-1:0] s1_b_reg;
    logic [FRAC_BITS-1:0]       s1_fx_reg;
    logic [FRAC_BITS-1:0]       s1_fy_reg;

    logic signed [SAMPLE_W:0]    d1;
    logic signed [HXW+1:0]       m1;
    logic signed [HXW-1:0]       base1;
    logic signed [HXW+1:0]       h_wide;
    logic signed [HXW-1:0]       h;

    logic signed [HXW-1:0] hx1_hold_reg;
    logic                  s2_vld_reg;
    logic signed [HXW-1:0] s2_hx1_reg;
    logic signed [HXW-1:0] s2_hx2_reg;
    logic [FRAC_BITS-1:0]  s2_fy_reg;

    logic signed [HXW:0]   d2;
    logic signed [PW-1:0]  p2;

    logic                  s3_vld_reg;
    logic signed [HXW-1:0] s3_hx1_reg;
    logic signed [PW-1:0]  s3_p_reg;

    logic signed [PW-1:0]    p_sh;
    logic signed [SW-1:0]    r_wide;
    logic [SW-OUT_W:0]       r_top;
    logic [OUT_W-1:0]        r_sat;
    logic                    out_vld_reg;
    logic [OUT_W-1:0]        out_reg;

    // whole back end moves only when the output register can take a word
    assign adv   = !out_vld_reg || m_tready;
    assign issue = adv && !q_empty;
    assign we    = issue && !q_head.is_query;
    assign re    = issue && q_head.is_query;
    assign q_pop = we || (re && phase_reg == PH_ROW1);

    assign row_sel = (phase_reg == PH_ROW1) ? RW'(q_head.row1) : RW'(q_head.row0);
    assign addr_a  = {row_sel, CW'(q_head.col0)};
    assign addr_b  = {row_sel, CW'(q_head.col1)};
    assign waddr   = {RW'(q_head.row0), CW'(q_head.col0)};

    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_ROW0: begin
                if (re) begin
                    phase_next = PH_ROW1;
                end
            end
            PH_ROW1: begin
                if (re) begin
                    phase_next = PH_ROW0;
                end
            end
            default: begin
                phase_next = PH_ROW0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_ROW0;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // grid store: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (we) begin
            grid_mem[waddr] <= q_head.sample;
        end
        if (re) begin
            s1_a_reg  <= grid_mem[addr_a];
            s1_b_reg  <= grid_mem[addr_b];
            s1_fx_reg <= FRAC_BITS'(q_head.fx);
            s1_fy_reg <= FRAC_BITS'(q_head.fy);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s1_ph_reg  <= PH_ROW0;
        end else if (adv) begin
            s1_vld_reg <= re;
            s1_ph_reg  <= phase_reg;
        end
    end

    // one row: a*2^F + fx*(b-a), exact
    assign d1     = $signed({s1_b_reg[SAMPLE_W-1], s1_b_reg})
                  - $signed({s1_a_reg[SAMPLE_W-1], s1_a_reg});
    assign m1     = $signed({1'b0, s1_fx_reg}) * d1;
    assign base1  = $signed({s1_a_reg, {FRAC_BITS{1'b0}}});
    assign h_wide = base1 + m1;
    assign h      = h_wide[HXW-1:0];

    always_ff @(posedge aclk) begin
        if (adv && s1_vld_reg) begin
            if (s1_ph_reg == PH_ROW0) begin
                hx1_hold_reg <= h;
            end else begin
                s2_hx1_reg <= hx1_hold_reg;
                s2_hx2_reg <= h;
                s2_fy_reg  <= s1_fy_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (adv) begin
            s2_vld_reg <= s1_vld_reg && (s1_ph_reg == PH_ROW1);
        end
    end

    assign d2 = s2_hx2_reg - s2_hx1_reg;
    assign p2 = $signed({1'b0, s2_fy_reg}) * d2;

    always_ff @(posedge aclk) begin
        if (adv && s2_vld_reg) begin
            s3_hx1_reg <= s2_hx1_reg;
            s3_p_reg   <= p2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_vld_reg <= 1'b0;
        end else if (adv) begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    // floor shift, add, saturate to the output range
    assign p_sh   = s3_p_reg >>> FRAC_BITS;
    assign r_wide = SW'(s3_hx1_reg) + SW'(p_sh);
    assign r_top  = r_wide[SW-1:OUT_W-1];

    always_comb begin
        if ((&r_top) || !(|r_top)) begin
            r_sat = r_wide[OUT_W-1:0];
        end else if (r_wide[SW-1]) begin
            r_sat = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            r_sat = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s3_vld_reg) begin
            out_reg <= r_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= s3_vld_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    a_second_row_completes: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && s1_vld_reg && s1_ph_reg == PH_ROW1) |=> s2_vld_reg)
        else $error("second row read did not reach the mix stage");

    a_query_pops_after_both_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_head.is_query) |-> (phase_reg == PH_ROW1))
        else $error("query left the queue before its second row was read");

    a_result_reaches_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && s3_vld_reg) |=> m_tvalid)
        else $error("finished result was not presented");

    a_no_write_mid_query: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_ROW1) |-> !we)
        else $error("grid write issued between the two rows of a query");

endmodule

@@ hdl/grid_bilinear_interpolator.sv @@
// Terrain height grid with bilinear lookup. A word with tuser 0 stores one signed
// 16-bit sample at (write_col, write_row) and returns nothing; writes outside
// MAX_COLS x MAX_ROWS are dropped. A word with tuser 1 returns one height with
// FRAC_BITS fraction bits, clamped to the grid size set over APB (grid_width at
// 0x0, grid_height at 0x4, each held between 2 and the maximum). A write takes
// one step and a query two, one per grid row, since the grid memory reads two
// samples per cycle while the back end advances; a query's result passes
// through the s1, s2 and s3 registers into the output register. A two-word queue
// sits between input and the memory, and an output register holds the result, so
// either side may stall alone. Only read cells that have been written.
module grid_bilinear_interpolator
    import gbi_pkg::*;
#(
    parameter int MAX_COLS  = 256,
    parameter int MAX_ROWS  = 256,
    parameter int FRAC_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // write_col, write_row, sample_height, x_pos, y_pos
    input  logic        s_tuser,   // kind

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // height_out

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);

    logic [8:0]    grid_width_reg;
    logic [8:0]    grid_height_reg;
    logic          cfg_wr;
    logic [CW-1:0] last_col;
    logic [RW-1:0] last_row;

    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_empty;
    gbi_item_t q_in;
    gbi_item_t q_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_GRID_HEIGHT) ? {23'b0, grid_height_reg}
                                                 : {23'b0, grid_width_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= 9'd256;
            grid_height_reg <= 9'd256;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_GRID_WIDTH) begin
                grid_width_reg <= pwdata[8:0];
            end else begin
                grid_height_reg <= pwdata[8:0];
            end
        end
    end

    always_comb begin
        if (grid_width_reg < 9'd2) begin
            last_col = CW'(1);
        end else if (32'(grid_width_reg) > MAX_COLS) begin
            last_col = CW'(MAX_COLS - 1);
        end else begin
            last_col = CW'(grid_width_reg - 9'd1);
        end
        if (grid_height_reg < 9'd2) begin
            last_row = RW'(1);
        end else if (32'(grid_height_reg) > MAX_ROWS) begin
            last_row = RW'(MAX_ROWS - 1);
        end else begin
            last_row = RW'(grid_height_reg - 9'd1);
        end
    end

    gbi_front #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .last_col (last_col),
        .last_row (last_row),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in)
    );

    gbi_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .item_in  (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .item_out (q_head),
        .empty    (q_empty)
    );

    gbi_back #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ test/grid_bilinear_interpolator_tb.sv @@
module grid_bilinear_interpolator_tb;
    import gbi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     GRID_MAX    = 256;
    localparam int     FRAC        = 8;
    localparam longint HEIGHT_MAX  = 64'sd8388607;
    localparam longint HEIGHT_MIN  = -64'sd8388608;
    localparam int     PHASES      = 9;
    localparam int     PHASE_WORDS = 205;
    localparam int     HOLD_CYCLES = 400;
    localparam int     DRAIN_CYCLES = 12;

    typedef enum logic [1:0] {
        ACT_SAMPLE,
        ACT_QUERY,
        ACT_CONFIG
    } step_act_t;

    typedef struct packed {
        step_act_t   act;
        logic [15:0] a;      // col, x_pos or register index
        logic [15:0] b;      // row, y_pos or register value
        logic [15:0] c;      // sample_height
        logic        typed;
        logic [23:0] height;
    } plan_step_t;

    localparam int PLAN_LEN = 25;
    localparam plan_step_t PLAN [PLAN_LEN] = '{
        '{ACT_SAMPLE, 16'd0,    16'd0,    16'h7FFF, 1'b0, 24'h000000},
        '{ACT_SAMPLE, 16'd1,    16'd0,    16'h8000, 1'b0, 24'h000000},
        '{ACT_SAMPLE, 16'd0,    16'd1,    16'h0000, 1'b0, 24'h000000},
        '{ACT_SAMPLE, 16'd1,    16'd1,    16'h04D2, 1'b0, 24'h000000},
        '{ACT_QUERY,  16'h0000, 16'h0000, 16'h0000, 1'b1, 24'h7FFF00},
        '{ACT_QUERY,  16'h0100, 16'h0100, 16'h0000, 1'b1, 24'h04D200},
        '{ACT_QUERY,  16'h0080, 16'h0000, 16'h0000, 1'b0, 24'h000000},
        '{ACT_QUERY,  16'h00FF, 16'h00FF, 16'h0000, 1'b0, 24'h000000},
        '{ACT_QUERY,  16'h0040, 16'h00C0, 16'h0000, 1'b0, 24'h000000},
        '{ACT_SAMPLE, 16'd255,  16'd255,  16'h8000, 1'b0, 24'h000000},
        '{ACT_SAMPLE, 16'd254,  16'd255,  16'h7FFF, 1'b0, 24'h000000},
        '{ACT_SAMPLE, 16'd255,  16'd254,  16'h0001, 1'b0, 24'h000000},
        '{ACT_SAMPLE, 16'd254,  16'd254,  16'hFFFF, 1'b0, 24'h000000},
        '{ACT_QUERY,  16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, 24'h800000},
        '{ACT_QUERY,  16'hFF00, 16'hFE80, 16'h0000, 1'b0, 24'h000000},
        '{ACT_QUERY,  16'hFE40, 16'hFFFF, 16'h0000, 1'b0, 24'h000000},
        '{ACT_QUERY,  16'hFEFF, 16'hFEFF, 16'h0000, 1'b0, 24'h000000},
        '{ACT_CONFIG, 16'(REG_GRID_WIDTH),  16'd0, 16'h0000, 1'b0, 24'h000000},
        '{ACT_CONFIG, 16'(REG_GRID_HEIGHT), 16'd1, 16'h0000, 1'b0, 24'h000000},
        '{ACT_QUERY,  16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, 24'h04D200},
        '{ACT_QUERY,  16'h0180, 16'h0040, 16'h0000, 1'b0, 24'h000000},
        '{ACT_QUERY,  16'h0040, 16'h7F80, 16'h0000, 1'b0, 24'h000000},
        '{ACT_CONFIG, 16'(REG_GRID_WIDTH),  16'd511, 16'h0000, 1'b0, 24'h000000},
        '{ACT_CONFIG, 16'(REG_GRID_HEIGHT), 16'd511, 16'h0000, 1'b0, 24'h000000},
        '{ACT_QUERY,  16'h0000, 16'h0100, 16'h0000, 1'b1, 24'h000000}
    };

    localparam int PHASE_COLS [PHASES] = '{256, 2, 0, 3, 511, 17, 64, 130, 256};
    localparam int PHASE_ROWS [PHASES] = '{256, 2, 1, 9, 300, 2, 5, 256, 256};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic signed [15:0] terrain [0:GRID_MAX*GRID_MAX-1];
    bit                 terrain_set [0:GRID_MAX*GRID_MAX-1];
    logic [8:0]         cfg_cols = 9'd256;
    logic [8:0]         cfg_rows = 9'd256;
    logic [23:0]        pending_heights [$];
    int                 words_sent = 0;
    int                 mismatches = 0;
    bit                 idle_on = 1'b1;
    bit                 sink_hold = 1'b0;

    grid_bilinear_interpolator uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int used_size(input logic [8:0] v);
        if (v < 9'd2) begin
            return 2;
        end
        if (v > 9'(GRID_MAX)) begin
            return GRID_MAX;
        end
        return int'(v);
    endfunction

    function automatic longint scaled(input int col, input int row);
        return longint'(terrain[row*GRID_MAX + col]) * (longint'(1) << FRAC);
    endfunction

    function automatic longint blend(input longint a, input longint b, input longint f);
        return a + ((f * (b - a)) >>> FRAC);
    endfunction

    function automatic logic [23:0] predict_height(input logic [15:0] x, input logic [15:0] y);
        int     w, h, i1, j1;
        longint fx, fy, r;
        w = used_size(cfg_cols);
        h = used_size(cfg_rows);
        i1 = int'(x >> FRAC);
        j1 = int'(y >> FRAC);
        fx = longint'(x[FRAC-1:0]);
        fy = longint'(y[FRAC-1:0]);
        if (i1 > w - 1) begin
            i1 = w - 1;
        end
        if (j1 > h - 1) begin
            j1 = h - 1;
        end
        if (i1 == w - 1 && j1 == h - 1) begin
            r = scaled(i1, j1);
        end else if (i1 == w - 1) begin
            r = blend(scaled(i1, j1), scaled(i1, j1 + 1), fy);
        end else if (j1 == h - 1) begin
            r = blend(scaled(i1, j1), scaled(i1 + 1, j1), fx);
        end else begin
            r = blend(blend(scaled(i1, j1), scaled(i1 + 1, j1), fx),
                      blend(scaled(i1, j1 + 1), scaled(i1 + 1, j1 + 1), fx), fy);
        end
        if (r > HEIGHT_MAX) begin
            r = HEIGHT_MAX;
        end
        if (r < HEIGHT_MIN) begin
            r = HEIGHT_MIN;
        end
        return r[23:0];
    endfunction

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(input logic kind, input logic [63:0] data);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = data;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic put_sample(input logic [7:0] col, input logic [7:0] row,
                              input logic [15:0] value);
        terrain[{row, col}]     = value;
        terrain_set[{row, col}] = 1'b1;
        send_word(KIND_WRITE, {32'($urandom), value, row, col});
    endtask

    task automatic ask_height(input logic [15:0] x, input logic [15:0] y,
                              input logic typed, input logic [23:0] given);
        int          w, h, i1, j1, c, r;
        logic [23:0] want;
        w = used_size(cfg_cols);
        h = used_size(cfg_rows);
        i1 = int'(x >> FRAC);
        j1 = int'(y >> FRAC);
        if (i1 > w - 1) begin
            i1 = w - 1;
        end
        if (j1 > h - 1) begin
            j1 = h - 1;
        end
        // every cell the lookup may touch must hold a sample first
        for (c = i1; c <= i1 + 1 && c < GRID_MAX; c++) begin
            for (r = j1; r <= j1 + 1 && r < GRID_MAX; r++) begin
                if (!terrain_set[r*GRID_MAX + c]) begin
                    put_sample(8'(c), 8'(r), 16'($urandom));
                end
            end
        end
        want = typed ? given : predict_height(x, y);
        send_word(KIND_QUERY, {y, x, 32'($urandom)});
        pending_heights.push_back(want);
    endtask

    task automatic settle();
        s_tvalid = 1'b0;
        while (pending_heights.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic sel, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {sel, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (sel == REG_GRID_WIDTH) begin
            cfg_cols = value[8:0];
        end else begin
            cfg_rows = value[8:0];
        end
    endtask

    function automatic logic [7:0] pick_index(input int size);
        int v;
        if ($urandom_range(0, 3) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        v = $urandom_range(0, size);
        return (v > 255) ? 8'd255 : 8'(v);
    endfunction

    function automatic logic [15:0] pick_coord(input int size);
        int          ip;
        logic [7:0]  fr;
        if ($urandom_range(0, 9) == 0) begin
            return 16'($urandom);
        end
        ip = $urandom_range(0, size + 1);
        if (ip > 255) begin
            ip = 255;
        end
        case ($urandom_range(0, 7))
            0: fr = 8'h00;
            1: fr = 8'hFF;
            default: fr = 8'($urandom);
        endcase
        return {8'(ip), fr};
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge aclk) begin
        logic [23:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_heights.size() == 0) begin
                $display("%0t: unexpected word, expected none, got height_out %0d",
                         $time, $signed(m_tdata));
                mismatches++;
            end else begin
                want = pending_heights.pop_front();
                if (m_tdata !== want) begin
                    $display("%0t: height_out expected %0d got %0d",
                             $time, $signed(want), $signed(m_tdata));
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int gap;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            gap = idle_on ? $urandom_range(0, 3) : 0;
            if (sink_hold) begin
                sink_hold = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int  k, ph, stop_at, w, h;
        bit  paused;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        for (k = 0; k < PLAN_LEN; k++) begin
            case (PLAN[k].act)
                ACT_SAMPLE: put_sample(PLAN[k].a[7:0], PLAN[k].b[7:0], PLAN[k].c);
                ACT_QUERY:  ask_height(PLAN[k].a, PLAN[k].b, PLAN[k].typed, PLAN[k].height);
                default: begin
                    settle();
                    write_reg(PLAN[k].a[0], 32'(PLAN[k].b));
                end
            endcase
        end

        for (ph = 0; ph < PHASES; ph++) begin
            settle();
            if (ph == PHASES - 1) begin
                write_reg(REG_GRID_WIDTH, 32'($urandom_range(0, 511)));
                write_reg(REG_GRID_HEIGHT, 32'($urandom_range(0, 511)));
            end else begin
                write_reg(REG_GRID_WIDTH, 32'(PHASE_COLS[ph]));
                write_reg(REG_GRID_HEIGHT, 32'(PHASE_ROWS[ph]));
            end
            idle_on = (ph % 3 != 2);
            if (ph == 1) begin
                sink_hold = 1'b1;
            end
            stop_at = words_sent + PHASE_WORDS;
            paused = 1'b0;
            while (words_sent < stop_at) begin
                if (ph == 4 && !paused && words_sent >= stop_at - PHASE_WORDS / 2) begin
                    paused = 1'b1;
                    while (pending_heights.size() != 0) @(negedge aclk);
                end
                w = used_size(cfg_cols);
                h = used_size(cfg_rows);
                if ($urandom_range(0, 9) < 4) begin
                    put_sample(pick_index(w), pick_index(h), pick_sample());
                end else begin
                    ask_height(pick_coord(w), pick_coord(h), 1'b0, 24'd0);
                end
            end
        end

        s_tvalid = 1'b0;
        while (pending_heights.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/gbi_pkg.sv
hdl/gbi_front.sv
hdl/gbi_fifo.sv
hdl/gbi_back.sv
hdl/grid_bilinear_interpolator.sv
test/grid_bilinear_interpolator_tb.sv
